>>> design/bse_pkg.sv
// Shared types and constants for the billboard sprite expander.
// No dependencies; imported by the interfaces, the coordinate lane and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_RIGHT    = 3'd0,
    REG_CAM_UP       = 3'd1,
    REG_PIVOT_FLAGS  = 3'd2,
    REG_ATLAS_ENABLE = 3'd3,
    REG_ATLAS_ORIGIN = 3'd4,
    REG_ATLAS_STEP   = 3'd5
  } cfg_reg_e;

  localparam int unsigned PIV_LEFT_BIT   = 3;
  localparam int unsigned PIV_TOP_BIT    = 4;
  localparam int unsigned PIV_RIGHT_BIT  = 5;
  localparam int unsigned PIV_BOTTOM_BIT = 6;

  localparam logic [15:0] UV_ONE = 16'h1000;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } anchor_t;

  typedef struct packed {
    logic load_prod;
    logic load_out;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/bse_if.sv
// Channel interfaces: configuration writes, particle words and vertex words.
// Depends on bse_pkg for the configuration index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface bse_cfg_if;
  import bse_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface bse_particle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [30:0] scale;
  logic        [7:0]  red_in;
  logic        [7:0]  green_in;
  logic        [7:0]  blue_in;
  logic        [7:0]  alpha_in;
  logic        [7:0]  cell_col;
  logic        [7:0]  cell_row;
  logic               list_end;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output scale,
                  output red_in, output green_in, output blue_in, output alpha_in,
                  output cell_col, output cell_row, output list_end, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input scale,
                  input red_in, input green_in, input blue_in, input alpha_in,
                  input cell_col, input cell_row, input list_end, output ready);
endinterface

interface bse_vertex_if #(
  parameter int unsigned SLOT_W = 9
);
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic [7:0]         alpha_out;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [SLOT_W-1:0]  vertex_slot;
  logic               quad_last;
  logic               batch_flush;

  modport source (output valid, output vert_x, output vert_y, output vert_z,
                  output red_out, output green_out, output blue_out, output alpha_out,
                  output tex_u, output tex_v, output vertex_slot, output quad_last,
                  output batch_flush, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                  input red_out, input green_out, input blue_out, input alpha_out,
                  input tex_u, input tex_v, input vertex_slot, input quad_last,
                  input batch_flush, output ready);
endinterface

`default_nettype wire

>>> design/bse_coord_lane.sv
// One coordinate lane: corner offset, size multiply, rounding, centre add, saturation.
// Depends on bse_pkg for the anchor and stage control types.
`timescale 1ns / 1ps
`default_nettype none

module bse_coord_lane (
  input  wire logic               clk_i,
  input  wire bse_pkg::lane_ctrl_t ctrl_i,
  input  wire logic signed [31:0] pos_i,
  input  wire logic        [30:0] scale_i,
  input  wire logic signed [15:0] right_i,
  input  wire logic signed [15:0] up_i,
  input  wire bse_pkg::anchor_t   anchor_i,
  input  wire logic        [1:0]  corner_i,
  output logic signed      [31:0] coord_o
);
  import bse_pkg::*;

  localparam int unsigned OFF_W  = 19;
  localparam int unsigned PROD_W = 32 + OFF_W;
  localparam int unsigned RND_SH = 15;
  localparam int unsigned SHR_W  = PROD_W - RND_SH;
  localparam int unsigned SUM_W  = SHR_W + 1;

  function automatic logic signed [OFF_W-1:0] corner_offset(
    input logic signed [15:0] r,
    input logic signed [15:0] u,
    input anchor_t            a,
    input logic        [1:0]  c
  );
    logic signed [OFF_W-1:0] r1;
    logic signed [OFF_W-1:0] u1;
    logic signed [OFF_W-1:0] h;
    logic signed [OFF_W-1:0] v;
    logic                    side;
    logic                    upper;
    r1    = OFF_W'(r);
    u1    = OFF_W'(u);
    side  = (c == 2'd1) || (c == 2'd2);
    upper = (c == 2'd0) || (c == 2'd2);
    if (a.left) begin
      h = side ? (r1 <<< 1) : '0;
    end else if (a.right) begin
      h = side ? '0 : -(r1 <<< 1);
    end else begin
      h = side ? r1 : -r1;
    end
    if (a.top) begin
      v = upper ? (u1 <<< 1) : '0;
    end else if (a.bottom) begin
      v = upper ? '0 : -(u1 <<< 1);
    end else begin
      v = upper ? -u1 : u1;
    end
    return h + v;
  endfunction

  logic signed [OFF_W-1:0]  off;
  logic signed [31:0]       scale_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [31:0]       pos_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SUM_W-1:0]  sum;
  logic signed [31:0]       coord_d;
  logic signed [31:0]       coord_q;

  assign off     = corner_offset(right_i, up_i, anchor_i, corner_i);
  assign scale_s = signed'({1'b0, scale_i});
  assign prod_d  = PROD_W'(scale_s) * PROD_W'(off);

  assign rnd = prod_q + PROD_W'(1 << (RND_SH - 1));
  assign shr = rnd[PROD_W-1:RND_SH];
  assign sum = SUM_W'(shr) + SUM_W'(pos_q);

  always_comb begin
    if (sum[SUM_W-1:31] != {(SUM_W-31){sum[SUM_W-1]}}) begin
      coord_d = sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      coord_d = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
      pos_q  <= pos_i;
    end
    if (ctrl_i.load_out) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

>>> design/billboard_sprite_expander_unit.sv
// Billboard sprite expander: each corner is registered in the second stage and output
// stage, one vertex word per cycle while the output is not stalled; the next particle
// is taken as the last one's fourth corner moves on. The rate is set by the single
// vertex datapath (three coordinate multipliers shared over the four corners).
// Reset clears the configuration registers, the batch vertex count and all valid flags.
// Top level; depends on bse_pkg, bse_if and bse_coord_lane.
`timescale 1ns / 1ps
`default_nettype none

module billboard_sprite_expander_unit #(
  parameter int unsigned BATCH_VERTICES = 480
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bse_cfg_if.sink        cfg_i,
  bse_particle_if.sink   particle_i,
  bse_vertex_if.source   vertex_o
);
  import bse_pkg::*;

  localparam int unsigned SLOT_W = $clog2(BATCH_VERTICES);
  localparam int unsigned CNT_W  = SLOT_W + 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [30:0] scale;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [7:0]  alpha;
    logic        [7:0]  col;
    logic        [7:0]  row;
  } part_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [15:0]       u;
    logic [15:0]       v;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              flush;
  } attr_t;

  logic [47:0] cam_right_q;
  logic [47:0] cam_up_q;
  logic [6:0]  pivot_q;
  logic        atlas_en_q;
  logic [31:0] origin_q;
  logic [31:0] step_q;

  logic              s0_valid_q;
  part_t             part_q;
  logic [1:0]        corner_q;
  logic [SLOT_W-1:0] base_q;
  logic              flush_q;

  logic              s1_valid_q;
  attr_t             s1_q;
  attr_t             s1_d;
  logic              out_valid_q;
  attr_t             out_q;

  logic [SLOT_W-1:0] batch_q;
  logic [SLOT_W-1:0] batch_d;
  logic [CNT_W-1:0]  batch_peek;
  logic              flush_d;

  logic              in_accept;
  logic              adv1;
  logic              adv2;
  logic              corner_last;
  lane_ctrl_t        lane_ctrl;
  anchor_t           anchor;

  logic              u_sel;
  logic              v_sel;
  logic [24:0]       u_prod;
  logic [24:0]       v_prod;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_right_q <= '0;
      cam_up_q    <= '0;
      pivot_q     <= '0;
      atlas_en_q  <= 1'b0;
      origin_q    <= '0;
      step_q      <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_CAM_RIGHT:    cam_right_q <= cfg_i.data[47:0];
        REG_CAM_UP:       cam_up_q    <= cfg_i.data[47:0];
        REG_PIVOT_FLAGS:  pivot_q     <= cfg_i.data[6:0];
        REG_ATLAS_ENABLE: atlas_en_q  <= cfg_i.data[0];
        REG_ATLAS_ORIGIN: origin_q    <= cfg_i.data[31:0];
        REG_ATLAS_STEP:   step_q      <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  assign corner_last      = (corner_q == 2'd3);
  assign adv2             = s1_valid_q && (!out_valid_q || vertex_o.ready);
  assign adv1             = s0_valid_q && (!s1_valid_q || adv2);
  assign particle_i.ready = !s0_valid_q || (adv1 && corner_last);
  assign in_accept        = particle_i.valid && particle_i.ready;

  assign batch_peek = CNT_W'(batch_q) + CNT_W'(8);
  assign flush_d    = particle_i.list_end || (batch_peek > CNT_W'(BATCH_VERTICES));
  assign batch_d    = flush_d ? '0 : batch_q + SLOT_W'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q    <= '0;
      s0_valid_q <= 1'b0;
      corner_q   <= '0;
    end else begin
      if (in_accept) begin
        batch_q    <= batch_d;
        s0_valid_q <= 1'b1;
        corner_q   <= '0;
      end else if (adv1) begin
        corner_q <= corner_q + 2'd1;
        if (corner_last) begin
          s0_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      part_q.pos_x <= particle_i.pos_x;
      part_q.pos_y <= particle_i.pos_y;
      part_q.pos_z <= particle_i.pos_z;
      part_q.scale <= particle_i.scale;
      part_q.red   <= particle_i.red_in;
      part_q.green <= particle_i.green_in;
      part_q.blue  <= particle_i.blue_in;
      part_q.alpha <= particle_i.alpha_in;
      part_q.col   <= particle_i.cell_col;
      part_q.row   <= particle_i.cell_row;
      base_q       <= batch_q;
      flush_q      <= flush_d;
    end
  end

  assign u_sel  = (corner_q == 2'd1) || (corner_q == 2'd2);
  assign v_sel  = (corner_q == 2'd1) || (corner_q == 2'd3);
  assign u_prod = (25'(part_q.col) + 25'(u_sel)) * 25'(step_q[15:0]);
  assign v_prod = (25'(part_q.row) + 25'(v_sel)) * 25'(step_q[31:16]);

  always_comb begin
    s1_d.red   = part_q.red;
    s1_d.green = part_q.green;
    s1_d.blue  = part_q.blue;
    s1_d.alpha = part_q.alpha;
    if (atlas_en_q) begin
      s1_d.u = origin_q[15:0] + u_prod[15:0];
      s1_d.v = origin_q[31:16] + v_prod[15:0];
    end else begin
      s1_d.u = u_sel ? UV_ONE : '0;
      s1_d.v = v_sel ? UV_ONE : '0;
    end
    s1_d.slot  = base_q + SLOT_W'(corner_q);
    s1_d.last  = corner_last;
    s1_d.flush = corner_last && flush_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= 1'b1;
      end else if (adv2) begin
        s1_valid_q <= 1'b0;
      end
      if (adv2) begin
        out_valid_q <= 1'b1;
      end else if (vertex_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q <= s1_d;
    end
    if (adv2) begin
      out_q <= s1_q;
    end
  end

  assign lane_ctrl.load_prod = adv1;
  assign lane_ctrl.load_out  = adv2;
  assign anchor.left   = pivot_q[PIV_LEFT_BIT];
  assign anchor.right  = pivot_q[PIV_RIGHT_BIT];
  assign anchor.top    = pivot_q[PIV_TOP_BIT];
  assign anchor.bottom = pivot_q[PIV_BOTTOM_BIT];

  bse_coord_lane u_lane_x (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .pos_i    (part_q.pos_x),
    .scale_i  (part_q.scale),
    .right_i  (signed'(cam_right_q[15:0])),
    .up_i     (signed'(cam_up_q[15:0])),
    .anchor_i (anchor),
    .corner_i (corner_q),
    .coord_o  (vertex_o.vert_x)
  );

  bse_coord_lane u_lane_y (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .pos_i    (part_q.pos_y),
    .scale_i  (part_q.scale),
    .right_i  (signed'(cam_right_q[31:16])),
    .up_i     (signed'(cam_up_q[31:16])),
    .anchor_i (anchor),
    .corner_i (corner_q),
    .coord_o  (vertex_o.vert_y)
  );

  bse_coord_lane u_lane_z (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .pos_i    (part_q.pos_z),
    .scale_i  (part_q.scale),
    .right_i  (signed'(cam_right_q[47:32])),
    .up_i     (signed'(cam_up_q[47:32])),
    .anchor_i (anchor),
    .corner_i (corner_q),
    .coord_o  (vertex_o.vert_z)
  );

  assign vertex_o.valid       = out_valid_q;
  assign vertex_o.red_out     = out_q.red;
  assign vertex_o.green_out   = out_q.green;
  assign vertex_o.blue_out    = out_q.blue;
  assign vertex_o.alpha_out   = out_q.alpha;
  assign vertex_o.tex_u       = out_q.u;
  assign vertex_o.tex_v       = out_q.v;
  assign vertex_o.vertex_slot = out_q.slot;
  assign vertex_o.quad_last   = out_q.last;
  assign vertex_o.batch_flush = out_q.flush;

`ifndef NO_ASSERTIONS
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.slot[1:0] == 2'b11))
    else $error("quad_last on a slot that is not a fourth corner");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flush) |-> out_q.last)
    else $error("batch_flush without quad_last");

  a_batch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_q[1:0] == 2'b00) && (CNT_W'(batch_q) + CNT_W'(4) <= CNT_W'(BATCH_VERTICES)))
    else $error("batch count out of range");

  a_list_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && particle_i.list_end) |=> (batch_q == '0))
    else $error("batch count not cleared after list end");
`endif

endmodule

`default_nettype wire
